@@ rtl/internet_checksum_engine_core_assert.svh @@
// Assertion macros shared by the checksum engine RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef INTERNET_CHECKSUM_ENGINE_CORE_ASSERT_SVH
`define INTERNET_CHECKSUM_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ICE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ICE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ICE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ICE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/ice_pkg.sv @@
// Package for the Internet checksum engine: modes, constants, stage struct,
// and the ones' complement fold and pseudo header helpers. No dependencies.
package ice_pkg;

    typedef enum logic [1:0] {
        MODE_IP   = 2'd0,
        MODE_TCP  = 2'd1,
        MODE_UDP  = 2'd2,
        MODE_ICMP = 2'd3
    } t_mode;

    localparam logic [15:0] PROTO_TCP = 16'd6;
    localparam logic [15:0] PROTO_UDP = 16'd17;
    localparam logic [15:0] MASK_ODD  = 16'hFF00;
    localparam logic [15:0] SUM_ZERO  = 16'h0000;
    localparam logic [15:0] SUM_ONES  = 16'hFFFF;

    // word held in the input register
    typedef struct packed {
        logic        valid;
        logic        first;
        logic        last;
        t_mode       mode;
        logic [15:0] word;    // odd byte already masked
        logic [15:0] pseudo;  // folded pseudo header, zero when not used
    } t_stage_word;

    // Fold a sum of up to eight 16-bit terms with end-around carry.
    // A nonzero sum never folds to zero, matching word-by-word adds.
    function automatic logic [15:0] ice_fold19(input logic [18:0] s);
        logic [16:0] f1;
        logic [15:0] f2;
        f1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
        f2 = f1[15:0] + {15'b0, f1[16]};
        return f2;
    endfunction

    // Pseudo header: addresses, protocol and length; zero for ip/icmp.
    function automatic logic [15:0] ice_pseudo_sum(
        input t_mode       mode,
        input logic [31:0] src,
        input logic [31:0] dst,
        input logic [15:0] len
    );
        logic [15:0] proto;
        logic [18:0] s;
        proto = (mode == MODE_TCP) ? PROTO_TCP : PROTO_UDP;
        s = {3'b0, src[31:16]} + {3'b0, src[15:0]} + {3'b0, dst[31:16]}
          + {3'b0, dst[15:0]} + {3'b0, proto} + {3'b0, len};
        if ((mode == MODE_TCP) || (mode == MODE_UDP)) begin
            return ice_fold19(s);
        end
        return SUM_ZERO;
    endfunction

endpackage

@@ rtl/internet_checksum_engine_core.sv @@
// Top level of the streaming Internet checksum engine (ones' complement sum
// with pseudo header). Depends on ice_pkg, ice_in_stage and ice_accum.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall | mode, first/last/odd flags,
//          |           |                         | data word, addresses, seg length
//  out     | output    | o_out_valid/i_out_stall | o_checksum
//
// One word per clock is taken unless a last word is held by a stalled result;
// the sum loop is one end-around-carry add of running sum, pseudo header and
// word between the input and state registers. A checksum enters the result
// register when its last word leaves the input register.
// Synchronous active-low reset clears valid flags, running sum and mode.
// A stalled result holds back a last word and words behind it; others keep flowing.
module internet_checksum_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic        i_odd_byte,
    input  logic [15:0] i_data_word,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [15:0] i_segment_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_checksum
);
    import ice_pkg::*;

    t_stage_word stage;
    logic        advance;

    // input register and pseudo header
    ice_in_stage u_in_stage (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_first_word     (i_first_word),
        .i_last_word      (i_last_word),
        .i_odd_byte       (i_odd_byte),
        .i_data_word      (i_data_word),
        .i_source_address (i_source_address),
        .i_dest_address   (i_dest_address),
        .i_segment_length (i_segment_length),
        .i_advance        (advance),
        .o_stage          (stage)
    );

    // running sum and result register
    ice_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (stage),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_checksum  (o_checksum)
    );

endmodule

@@ rtl/ice_in_stage.sv @@
// Input register of the checksum engine: takes one word, masks the odd byte
// and precomputes the pseudo header sum. Depends on ice_pkg.
`include "internet_checksum_engine_core_assert.svh"

module ice_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic                 i_first_word,
    input  logic                 i_last_word,
    input  logic                 i_odd_byte,
    input  logic [15:0]          i_data_word,
    input  logic [31:0]          i_source_address,
    input  logic [31:0]          i_dest_address,
    input  logic [15:0]          i_segment_length,
    input  logic                 i_advance,
    output ice_pkg::t_stage_word o_stage
);
    import ice_pkg::*;

    logic        accept;
    logic        r_valid, n_valid;
    logic        r_first, r_last;
    t_mode       r_mode;
    logic [15:0] r_word, n_word;
    logic [15:0] r_pseudo, n_pseudo;

    // stall only while a held word cannot move on
    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    // odd byte mask and pseudo header, ahead of the register
    always_comb begin
        n_word   = (i_last_word && i_odd_byte) ? (i_data_word & MASK_ODD) : i_data_word;
        n_pseudo = i_first_word
                 ? ice_pseudo_sum(t_mode'(i_mode), i_source_address,
                                  i_dest_address, i_segment_length)
                 : SUM_ZERO;
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first  <= i_first_word;
            r_last   <= i_last_word;
            r_mode   <= t_mode'(i_mode);
            r_word   <= n_word;
            r_pseudo <= n_pseudo;
        end
    end

    assign o_stage = '{valid:  r_valid,
                       first:  r_first,
                       last:   r_last,
                       mode:   r_mode,
                       word:   r_word,
                       pseudo: r_pseudo};

    `ICE_ASSERT_SAME(a_stall_needs_word, i_clk, i_rst_n, o_in_stall, r_valid,
        "input stalled with empty stage")
    `ICE_ASSERT_SAME(a_advance_needs_word, i_clk, i_rst_n, i_advance, r_valid,
        "advance with empty stage")

endmodule

@@ rtl/ice_accum.sv @@
// Running ones' complement sum, packet mode and checksum result register.
// Depends on ice_pkg; fed by ice_in_stage.
`include "internet_checksum_engine_core_assert.svh"

module ice_accum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ice_pkg::t_stage_word i_stage,
    output logic                 o_advance,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [15:0]          o_checksum
);
    import ice_pkg::*;

    logic [15:0] r_running_sum, n_running_sum;
    t_mode       r_packet_mode, n_packet_mode;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_checksum, n_checksum;
    logic        out_free;
    logic        emit;
    logic [15:0] base;
    logic [17:0] raw_sum;
    logic [15:0] sum;
    logic [15:0] inv_sum;

    // a last word needs room in the result register, others always move
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_advance = i_stage.valid && (!i_stage.last || out_free);
    assign emit      = o_advance && i_stage.last;

    // one end-around-carry add of base, pseudo header and word
    always_comb begin
        base    = i_stage.first ? SUM_ZERO : r_running_sum;
        raw_sum = {2'b0, base} + {2'b0, i_stage.pseudo} + {2'b0, i_stage.word};
        sum     = ice_fold19({1'b0, raw_sum});
        inv_sum = ~sum;
    end

    // next state and result
    always_comb begin
        n_running_sum = r_running_sum;
        n_packet_mode = r_packet_mode;
        n_out_valid   = r_out_valid && i_out_stall;
        n_checksum    = r_checksum;
        if (o_advance) begin
            if (i_stage.first) begin
                n_packet_mode = i_stage.mode;
            end
            n_running_sum = i_stage.last ? SUM_ZERO : sum;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_checksum  = (n_packet_mode == MODE_UDP && inv_sum == SUM_ZERO)
                        ? SUM_ONES : inv_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum <= SUM_ZERO;
            r_packet_mode <= MODE_IP;
            r_out_valid   <= 1'b0;
        end else begin
            r_running_sum <= n_running_sum;
            r_packet_mode <= n_packet_mode;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_checksum <= n_checksum;
    end

    assign o_out_valid = r_out_valid;
    assign o_checksum  = r_checksum;

    `ICE_ASSERT_NEXT(a_sum_cleared_after_last, i_clk, i_rst_n, emit,
        r_running_sum == SUM_ZERO, "running sum not cleared after last word")
    `ICE_ASSERT_NEXT(a_result_only_from_last, i_clk, i_rst_n, out_free && !emit,
        !r_out_valid, "result appeared without a last word")
    `ICE_ASSERT_NEXT(a_udp_never_zero, i_clk, i_rst_n,
        emit && (n_packet_mode == MODE_UDP),
        r_checksum != SUM_ZERO, "udp checksum sent as zero")

endmodule

@@ dv/internet_checksum_engine_core_test.sv @@
// Self-checking testbench for internet_checksum_engine_core: streams packet words
// through the valid/stall channels and checks every checksum against a local model.
// Depends on ice_pkg and the engine RTL.
`timescale 1ns / 100ps

module internet_checksum_engine_core_test;
    import ice_pkg::*;

    localparam int TOTAL_WORDS  = 1950;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;

    // one input word and its pseudo header fields
    typedef struct {
        t_mode       mode;
        bit          first;
        bit          last;
        bit          odd;
        bit [15:0]   data;
        bit [31:0]   src;
        bit [31:0]   dst;
        bit [15:0]   len;
        bit          drain;  // hold this word until all checksums are back
    } t_csum_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic        i_first_word;
    logic        i_last_word;
    logic        i_odd_byte;
    logic [15:0] i_data_word;
    logic [31:0] i_source_address;
    logic [31:0] i_dest_address;
    logic [15:0] i_segment_length;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_checksum;

    t_csum_word  word_queue[$];
    bit [15:0]   checksum_queue[$];
    bit [15:0]   run_sum  = 16'h0000;
    t_mode       pkt_mode = MODE_IP;
    bit          word_taken = 1'b0;
    int          sent_count  = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;

    internet_checksum_engine_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_first_word     (i_first_word),
        .i_last_word      (i_last_word),
        .i_odd_byte       (i_odd_byte),
        .i_data_word      (i_data_word),
        .i_source_address (i_source_address),
        .i_dest_address   (i_dest_address),
        .i_segment_length (i_segment_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_checksum       (o_checksum)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ones' complement add with end-around carry
    function automatic bit [15:0] ones_add(input bit [15:0] a, input bit [15:0] b);
        bit [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    // pseudo header contribution; zero for ip header and icmp
    function automatic bit [15:0] pseudo_header_sum(input t_mode m, input bit [31:0] src,
                                                    input bit [31:0] dst, input bit [15:0] len);
        bit [15:0] acc;
        acc = 16'h0000;
        if (m == MODE_TCP || m == MODE_UDP) begin
            acc = ones_add(acc, src[31:16]);
            acc = ones_add(acc, src[15:0]);
            acc = ones_add(acc, dst[31:16]);
            acc = ones_add(acc, dst[15:0]);
            acc = ones_add(acc, (m == MODE_TCP) ? PROTO_TCP : PROTO_UDP);
            acc = ones_add(acc, len);
        end
        return acc;
    endfunction

    // advance the running sum by one word; returns 1 when a checksum is due
    function automatic bit sum_word(input t_csum_word w, output bit [15:0] csum);
        bit [15:0] acc;
        bit [15:0] data;
        acc  = run_sum;
        csum = 16'h0000;
        if (w.first) begin
            pkt_mode = w.mode;
            acc = pseudo_header_sum(w.mode, w.src, w.dst, w.len);
        end
        data = (w.last && w.odd) ? (w.data & MASK_ODD) : w.data;
        acc  = ones_add(acc, data);
        if (w.last) begin
            csum = ~acc;
            if (pkt_mode == MODE_UDP && csum == SUM_ZERO)
                csum = SUM_ONES;
            run_sum = 16'h0000;
            return 1'b1;
        end
        run_sum = acc;
        return 1'b0;
    endfunction

    function automatic void queue_word(input t_mode m, input bit first, input bit last,
                                       input bit odd, input bit [15:0] data,
                                       input bit [31:0] src, input bit [31:0] dst,
                                       input bit [15:0] len);
        t_csum_word w;
        w.mode  = m;
        w.first = first;
        w.last  = last;
        w.odd   = odd;
        w.data  = data;
        w.src   = src;
        w.dst   = dst;
        w.len   = len;
        w.drain = 1'b0;
        word_queue.push_back(w);
    endfunction

    // a packet of n words; a missing first or last word makes it a broken one
    function automatic void queue_packet(input t_mode m, input int n, input bit has_first,
                                         input bit has_last);
        bit [31:0] src;
        bit [31:0] dst;
        bit [15:0] len;
        bit        odd_end;
        bit        is_last;
        src     = $urandom;
        dst     = $urandom;
        odd_end = 1'($urandom_range(1));
        len     = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(2 * n - odd_end);
        for (int k = 0; k < n; k++) begin
            is_last = has_last && (k == n - 1);
            if (k == 0 && has_first)
                queue_word(m, 1'b1, is_last, is_last ? odd_end : 1'($urandom_range(1)),
                           16'($urandom), src, dst, len);
            else
                queue_word(t_mode'($urandom_range(3)), 1'b0, is_last,
                           is_last ? odd_end : ($urandom_range(7) == 0), 16'($urandom),
                           $urandom, $urandom, 16'($urandom));
        end
    endfunction

    function automatic int sender_idle_pct();
        if (sent_count < TOTAL_WORDS / 3)
            return 24;
        if (sent_count < 2 * TOTAL_WORDS / 3)
            return 55;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (sent_count < TOTAL_WORDS / 3)
            return 55;
        if (sent_count < 2 * TOTAL_WORDS / 3)
            return 24;
        return 0;
    endfunction

    // driver: new word or idle at the falling edge, held while stalled
    always @(negedge i_clk) begin
        t_csum_word w;
        bit         hold;
        if (i_rst_n) begin
            if (!i_in_valid || word_taken) begin
                hold = (word_queue.size() == 0) ||
                       ($urandom_range(99) < sender_idle_pct());
                if (!hold && word_queue[0].drain && checksum_queue.size() != 0)
                    hold = 1'b1;
                if (!hold) begin
                    w = word_queue.pop_front();
                    i_mode           <= w.mode;
                    i_first_word     <= w.first;
                    i_last_word      <= w.last;
                    i_odd_byte       <= w.odd;
                    i_data_word      <= w.data;
                    i_source_address <= w.src;
                    i_dest_address   <= w.dst;
                    i_segment_length <= w.len;
                    i_in_valid       <= 1'b1;
                    sent_count++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct());
        end
    end

    // monitor: predict on each taken word, check each taken checksum
    always @(posedge i_clk) begin
        t_csum_word w;
        bit [15:0]  csum;
        bit [15:0]  want;
        bit         in_fire;
        bit         out_fire;
        in_fire  = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        word_taken <= in_fire;
        if (in_fire) begin
            w.mode  = t_mode'(i_mode);
            w.first = i_first_word;
            w.last  = i_last_word;
            w.odd   = i_odd_byte;
            w.data  = i_data_word;
            w.src   = i_source_address;
            w.dst   = i_dest_address;
            w.len   = i_segment_length;
            w.drain = 1'b0;
            if (sum_word(w, csum))
                checksum_queue.push_back(csum);
        end
        if (out_fire) begin
            if (checksum_queue.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected checksum %h with none pending", o_checksum);
            end else begin
                want = checksum_queue.pop_front();
                if (o_checksum !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("checksum mismatch: expected %h, got %h", want, o_checksum);
                end
            end
        end
        quiet_cycles <= (in_fire || out_fire || !i_rst_n) ? 0 : quiet_cycles + 1;
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        bit [31:0] src;
        bit [31:0] dst;
        bit [15:0] len;
        bit [15:0] p;

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_mode           = MODE_IP;
        i_first_word     = 1'b0;
        i_last_word      = 1'b0;
        i_odd_byte       = 1'b0;
        i_data_word      = 16'h0000;
        i_source_address = 32'h0;
        i_dest_address   = 32'h0;
        i_segment_length = 16'h0000;
        i_out_stall      = 1'b0;

        // words before any first word sum under the reset mode (ip header)
        queue_word(MODE_UDP, 1'b0, 1'b0, 1'b1, 16'h1234, 32'hFFFF_FFFF, 32'h0, 16'hFFFF);
        queue_word(MODE_TCP, 1'b0, 1'b1, 1'b1, 16'hABCD, 32'h0, 32'h0, 16'h0000);
        // single-word packets: all zero, all ones, odd byte in icmp
        queue_word(MODE_IP, 1'b1, 1'b1, 1'b0, 16'h0000, 32'h0, 32'h0, 16'h0000);
        queue_word(MODE_IP, 1'b1, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        queue_word(MODE_ICMP, 1'b1, 1'b1, 1'b1, 16'h80FF, 32'h0, 32'h0, 16'h0000);
        queue_word(MODE_TCP, 1'b1, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   16'hFFFF);
        queue_word(MODE_UDP, 1'b1, 1'b1, 1'b0, 16'h0000, 32'h0, 32'h0, 16'h0000);
        // udp sum that complements to zero goes out as all ones; tcp keeps zero
        src = $urandom;
        dst = $urandom;
        len = 16'($urandom);
        p = pseudo_header_sum(MODE_UDP, src, dst, len);
        queue_word(MODE_UDP, 1'b1, 1'b1, 1'b0, ~p, src, dst, len);
        p = pseudo_header_sum(MODE_TCP, src, dst, len);
        queue_word(MODE_TCP, 1'b1, 1'b1, 1'b0, ~p, src, dst, len);
        // odd byte ignored mid packet, mode ignored on later words
        queue_word(MODE_TCP, 1'b1, 1'b0, 1'b0, 16'h4500, src, dst, 16'd5);
        queue_word(MODE_ICMP, 1'b0, 1'b0, 1'b1, 16'h00FF, 32'h0, 32'h0, 16'h0000);
        queue_word(MODE_IP, 1'b0, 1'b1, 1'b1, 16'hFFFF, 32'h0, 32'h0, 16'h0000);
        // a first word mid packet restarts the sum
        queue_word(MODE_UDP, 1'b1, 1'b0, 1'b0, 16'h5555, src, dst, len);
        queue_word(MODE_IP, 1'b1, 1'b1, 1'b0, 16'hAAAA, 32'h0, 32'h0, 16'h0000);
        word_queue[word_queue.size() - 1].drain = 1'b1;
        // full ip header
        queue_packet(MODE_IP, 10, 1'b1, 1'b1);

        // random packets, mostly well formed
        while (word_queue.size() < TOTAL_WORDS) begin
            case ($urandom_range(9))
                8:       queue_packet(t_mode'($urandom_range(3)), $urandom_range(1, 8),
                                      1'b1, 1'b0);
                9:       queue_packet(t_mode'($urandom_range(3)), $urandom_range(1, 8),
                                      1'b0, 1'b1);
                default: queue_packet(t_mode'($urandom_range(3)),
                                      ($urandom_range(15) == 0) ? $urandom_range(10, 40)
                                                                : $urandom_range(1, 12),
                                      1'b1, 1'b1);
            endcase
        end
        word_queue[TOTAL_WORDS / 2].drain = 1'b1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(word_queue.size() == 0 && !i_in_valid && checksum_queue.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (checksum_queue.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ice_pkg.sv
rtl/ice_in_stage.sv
rtl/ice_accum.sv
rtl/internet_checksum_engine_core.sv
dv/internet_checksum_engine_core_test.sv
